### sv/bgsp_pkg.sv
// Shared types, codes and reset constants for the button gesture servo positioner.
package bgsp_pkg;

    localparam int SCAN_MS_DEFAULT   = 5;
    localparam int TIME_BITS_DEFAULT = 32;

    localparam int CFG_WIDTH = 16;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_BITS = $clog2(NUM_CFG);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DOUBLE_GAP   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLDOFF      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SERVO_HOLD   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_SINGLE = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_DOUBLE = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_LONG   = 3'd7;

    localparam logic [CFG_WIDTH-1:0] CFG_RESET [NUM_CFG] = '{
        16'd20, 16'd700, 16'd350, 16'd500, 16'd200, 16'd500, 16'd1500, 16'd2500
    };

    typedef enum logic [3:0] {
        R_IDLE          = 4'd0,
        R_HELD          = 4'd1,
        R_GAP_WAIT      = 4'd2,
        R_CLASSIFY      = 4'd3,
        R_PRESS_CHECK   = 4'd4,
        R_SECOND_CHECK  = 4'd5,
        R_RELEASE_CHECK = 4'd6,
        R_STAMP_END     = 4'd7,
        R_HOLDOFF       = 4'd8
    } t_rec_state;

    typedef enum logic [1:0] {
        S_FREE  = 2'd0,
        S_BUSY  = 2'd1,
        S_START = 2'd2
    } t_servo_phase;

    typedef enum logic [1:0] {
        G_NONE   = 2'd0,
        G_SINGLE = 2'd1,
        G_DOUBLE = 2'd2,
        G_LONG   = 2'd3
    } t_gesture;

    typedef struct packed {
        logic press_edge;
        logic key_level;
    } t_in_word;

    typedef struct packed {
        logic [15:0] pulse_width;
        logic        pulse_update;
        logic [1:0]  gesture;
        logic        servo_active;
    } t_out_word;

endpackage

### sv/bgsp_stream_if.sv
// Valid/ready stream channel carrying one word of type T.
interface bgsp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/button_gesture_servo_positioner_top.sv
// Button gesture recognizer driving a servo compare value, top level.
//
// Input channel i_in: one word per millisecond tick, carrying the falling-edge
// flag and the button level (0 = pressed). Output channel o_out: exactly one
// word per input word, with the current compare value, the update strobe, the
// gesture found on that tick and the servo busy flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (debounce,
// long press, double gap, holdoff, servo hold, three compare values). Write
// only while no word is in flight.
// The result word is registered and valid in the cycle after its input word is taken.
// Throughput: one word per cycle while the output word is taken; the whole
// recognizer and servo step is one pass of compare-and-select logic between
// the state registers and the output register.
// Reset (synchronous, i_rst_n low): time counters, recognizer and servo go to
// zero/idle, compare value to 0, registers to their defaults, output empty.
// Stall: while the output word is not taken, it holds and i_in.ready drops;
// the held word leaving frees the slot in the same cycle.
module button_gesture_servo_positioner_top
    import bgsp_pkg::*;
#(
    parameter int SCAN_MS   = SCAN_MS_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]    i_cfg_data,
    bgsp_stream_if.sink             i_in,
    bgsp_stream_if.source           o_out
);

    typedef logic [TIME_BITS-1:0] t_time;

    logic [CFG_WIDTH-1:0] r_cfg [NUM_CFG];

    t_time        r_tick, n_tick;
    t_time        r_last_scan, n_last_scan;
    logic         r_latch, n_latch;
    t_rec_state   r_rec, n_rec;
    t_time        r_first_press, n_first_press;
    t_time        r_release, n_release;
    t_time        r_second_press, n_second_press;
    t_time        r_gesture_end, n_gesture_end;
    t_gesture     r_pending, n_pending;
    t_servo_phase r_servo, n_servo;
    t_time        r_servo_start, n_servo_start;
    logic [15:0]  r_compare, n_compare;

    logic      r_out_valid;
    t_out_word r_out_data, n_out_data;

    logic     accept;
    t_gesture gest;
    logic     upd;
    logic     scan;
    t_time    debounce_t, long_t, gap_t, holdoff_t, servo_hold_t;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    assign debounce_t   = t_time'(r_cfg[CFG_DEBOUNCE]);
    assign long_t       = t_time'(r_cfg[CFG_LONG_PRESS]);
    assign gap_t        = t_time'(r_cfg[CFG_DOUBLE_GAP]);
    assign holdoff_t    = t_time'(r_cfg[CFG_HOLDOFF]);
    assign servo_hold_t = t_time'(r_cfg[CFG_SERVO_HOLD]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        n_tick         = r_tick + t_time'(1);
        n_last_scan    = r_last_scan;
        n_latch        = r_latch || i_in.data.press_edge;
        n_rec          = r_rec;
        n_first_press  = r_first_press;
        n_release      = r_release;
        n_second_press = r_second_press;
        n_gesture_end  = r_gesture_end;
        n_pending      = r_pending;
        n_servo        = r_servo;
        n_servo_start  = r_servo_start;
        n_compare      = r_compare;
        gest           = G_NONE;
        upd            = 1'b0;

        scan = (n_tick - r_last_scan) >= t_time'(SCAN_MS);
        if (scan) begin
            n_last_scan = n_tick;
            unique case (r_rec)
                R_IDLE: begin
                    if (n_latch) begin
                        n_first_press = n_tick;
                        n_rec         = R_PRESS_CHECK;
                        n_latch       = 1'b0;
                    end
                end
                R_PRESS_CHECK: begin
                    if ((n_tick - r_first_press) >= debounce_t)
                        n_rec = !i_in.data.key_level ? R_HELD : R_IDLE;
                end
                R_HELD: begin
                    if (i_in.data.key_level) begin
                        n_release = n_tick;
                        n_rec     = R_RELEASE_CHECK;
                    end
                end
                R_RELEASE_CHECK: begin
                    if ((n_tick - r_release) >= debounce_t)
                        n_rec = i_in.data.key_level ? R_CLASSIFY : R_HELD;
                end
                R_CLASSIFY: begin
                    if ((r_release - r_first_press) >= long_t) begin
                        gest  = G_LONG;
                        n_rec = R_STAMP_END;
                    end else begin
                        n_rec = R_GAP_WAIT;
                    end
                end
                R_GAP_WAIT: begin
                    if ((n_tick - r_release) <= gap_t) begin
                        if (!i_in.data.key_level) begin
                            n_second_press = n_tick;
                            n_rec          = R_SECOND_CHECK;
                        end
                    end else begin
                        gest  = G_SINGLE;
                        n_rec = R_STAMP_END;
                    end
                end
                R_SECOND_CHECK: begin
                    if ((n_tick - r_second_press) >= debounce_t) begin
                        if (!i_in.data.key_level) begin
                            gest  = G_DOUBLE;
                            n_rec = R_STAMP_END;
                        end else begin
                            n_rec = R_GAP_WAIT;
                        end
                    end
                end
                R_STAMP_END: begin
                    n_gesture_end = n_tick;
                    n_rec         = R_HOLDOFF;
                end
                R_HOLDOFF: begin
                    if ((n_tick - r_gesture_end) >= holdoff_t)
                        n_rec = R_IDLE;
                end
                default: n_rec = R_IDLE;
            endcase
            if (gest != G_NONE)
                n_pending = gest;
        end

        // servo sees a gesture found on this same tick
        unique case (r_servo)
            S_START: begin
                n_servo_start = n_tick;
                n_servo       = S_BUSY;
            end
            S_BUSY: begin
                if ((n_tick - r_servo_start) >= servo_hold_t)
                    n_servo = S_FREE;
            end
            default: begin
                n_servo = S_FREE;
                if (n_pending != G_NONE) begin
                    unique case (n_pending)
                        G_SINGLE: n_compare = r_cfg[CFG_PULSE_SINGLE];
                        G_DOUBLE: n_compare = r_cfg[CFG_PULSE_DOUBLE];
                        default:  n_compare = r_cfg[CFG_PULSE_LONG];
                    endcase
                    n_pending = G_NONE;
                    n_servo   = S_START;
                    upd       = 1'b1;
                end
            end
        endcase

        n_out_data.pulse_width  = n_compare;
        n_out_data.pulse_update = upd;
        n_out_data.gesture      = gest;
        n_out_data.servo_active = (n_servo != S_FREE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick         <= '0;
            r_last_scan    <= '0;
            r_latch        <= 1'b0;
            r_rec          <= R_IDLE;
            r_first_press  <= '0;
            r_release      <= '0;
            r_second_press <= '0;
            r_gesture_end  <= '0;
            r_pending      <= G_NONE;
            r_servo        <= S_FREE;
            r_servo_start  <= '0;
            r_compare      <= '0;
        end else if (accept) begin
            r_tick         <= n_tick;
            r_last_scan    <= n_last_scan;
            r_latch        <= n_latch;
            r_rec          <= n_rec;
            r_first_press  <= n_first_press;
            r_release      <= n_release;
            r_second_press <= n_second_press;
            r_gesture_end  <= n_gesture_end;
            r_pending      <= n_pending;
            r_servo        <= n_servo;
            r_servo_start  <= n_servo_start;
            r_compare      <= n_compare;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

### verif/tb_button_gesture_servo_positioner_top.sv
// Testbench for the button gesture servo positioner: tick stimulus, predictor and word checker.
`timescale 1ns / 1ps

module tb_button_gesture_servo_positioner_top;
    import bgsp_pkg::*;

    localparam int unsigned SCAN_PERIOD = SCAN_MS_DEFAULT;
    localparam int          RANDOM_WORDS = 200;
    localparam int          CALM_AFTER   = 130;
    localparam int          LONG_STALL   = 64;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          MAX_REPORTS  = 10;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_WIDTH-1:0]    i_cfg_data;

    bgsp_stream_if #(.T(t_in_word))  tick_ch ();
    bgsp_stream_if #(.T(t_out_word)) pwm_ch ();

    button_gesture_servo_positioner_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_ch),
        .o_out      (pwm_ch)
    );

    // predictor state
    logic [CFG_WIDTH-1:0] cfg_regs [NUM_CFG];
    logic [CFG_WIDTH-1:0] cfg_plan [NUM_CFG];
    logic [31:0]          ms_now;
    logic [31:0]          last_scan;
    logic [31:0]          first_press_t;
    logic [31:0]          release_t;
    logic [31:0]          second_press_t;
    logic [31:0]          gesture_end_t;
    logic [31:0]          servo_start_t;
    logic                 edge_latched;
    t_rec_state           rec_st;
    t_gesture             queued_gesture;
    t_servo_phase         servo_st;
    logic [15:0]          cmp_val;

    t_out_word            pwm_expect_q [$];
    t_out_word            want_w;

    // bookkeeping
    int  mismatches;
    int  words_sent;
    int  random_words;
    int  cfg_loads;
    int  n_single;
    int  n_double;
    int  n_long;
    int  n_updates;
    int  cycle_cnt;
    bit  calm_tail;
    bit  hold_output;

    function automatic logic [31:0] ms_since(logic [31:0] later, logic [31:0] earlier);
        return later - earlier;
    endfunction

    // One millisecond tick of the recognizer and servo machine.
    function automatic t_out_word step_gesture_servo(t_in_word w);
        t_gesture  found;
        t_out_word res;
        logic      upd;
        found = G_NONE;
        upd   = 1'b0;
        ms_now = ms_now + 32'd1;
        if (w.press_edge)
            edge_latched = 1'b1;

        if (ms_since(ms_now, last_scan) >= SCAN_PERIOD) begin
            last_scan = ms_now;
            case (rec_st)
                R_IDLE: begin
                    if (edge_latched) begin
                        first_press_t = ms_now;
                        rec_st        = R_PRESS_CHECK;
                        edge_latched  = 1'b0;
                    end
                end
                R_PRESS_CHECK: begin
                    if (ms_since(ms_now, first_press_t) >= cfg_regs[CFG_DEBOUNCE])
                        rec_st = w.key_level ? R_IDLE : R_HELD;
                end
                R_HELD: begin
                    if (w.key_level) begin
                        release_t = ms_now;
                        rec_st    = R_RELEASE_CHECK;
                    end
                end
                R_RELEASE_CHECK: begin
                    if (ms_since(ms_now, release_t) >= cfg_regs[CFG_DEBOUNCE])
                        rec_st = w.key_level ? R_CLASSIFY : R_HELD;
                end
                R_CLASSIFY: begin
                    if (ms_since(release_t, first_press_t) >= cfg_regs[CFG_LONG_PRESS]) begin
                        found  = G_LONG;
                        rec_st = R_STAMP_END;
                    end else begin
                        rec_st = R_GAP_WAIT;
                    end
                end
                R_GAP_WAIT: begin
                    if (ms_since(ms_now, release_t) <= cfg_regs[CFG_DOUBLE_GAP]) begin
                        if (!w.key_level) begin
                            second_press_t = ms_now;
                            rec_st         = R_SECOND_CHECK;
                        end
                    end else begin
                        found  = G_SINGLE;
                        rec_st = R_STAMP_END;
                    end
                end
                R_SECOND_CHECK: begin
                    if (ms_since(ms_now, second_press_t) >= cfg_regs[CFG_DEBOUNCE]) begin
                        if (!w.key_level) begin
                            found  = G_DOUBLE;
                            rec_st = R_STAMP_END;
                        end else begin
                            rec_st = R_GAP_WAIT;
                        end
                    end
                end
                R_STAMP_END: begin
                    gesture_end_t = ms_now;
                    rec_st        = R_HOLDOFF;
                end
                R_HOLDOFF: begin
                    if (ms_since(ms_now, gesture_end_t) >= cfg_regs[CFG_HOLDOFF])
                        rec_st = R_IDLE;
                end
                default: rec_st = R_IDLE;
            endcase
            // a newer gesture overwrites one still waiting for the servo
            if (found != G_NONE)
                queued_gesture = found;
        end

        case (servo_st)
            S_START: begin
                servo_start_t = ms_now;
                servo_st      = S_BUSY;
            end
            S_BUSY: begin
                if (ms_since(ms_now, servo_start_t) >= cfg_regs[CFG_SERVO_HOLD])
                    servo_st = S_FREE;
            end
            default: begin
                servo_st = S_FREE;
                if (queued_gesture != G_NONE) begin
                    case (queued_gesture)
                        G_SINGLE: cmp_val = cfg_regs[CFG_PULSE_SINGLE];
                        G_DOUBLE: cmp_val = cfg_regs[CFG_PULSE_DOUBLE];
                        default:  cmp_val = cfg_regs[CFG_PULSE_LONG];
                    endcase
                    queued_gesture = G_NONE;
                    servo_st       = S_START;
                    upd            = 1'b1;
                end
            end
        endcase

        res.pulse_width  = cmp_val;
        res.pulse_update = upd;
        res.gesture      = found;
        res.servo_active = (servo_st != S_FREE);
        return res;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d got %0d", $realtime, fname, want, got);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // predict on each accepted tick, check each accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tick_ch.valid && tick_ch.ready)
                pwm_expect_q.push_back(step_gesture_servo(tick_ch.data));
            if (pwm_ch.valid && pwm_ch.ready) begin
                if (pwm_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result word with nothing expected", $realtime);
                end else begin
                    want_w = pwm_expect_q.pop_front();
                    check_field("pulse_width", want_w.pulse_width, pwm_ch.data.pulse_width);
                    check_field("pulse_update", 16'(want_w.pulse_update),
                                16'(pwm_ch.data.pulse_update));
                    check_field("gesture", 16'(want_w.gesture), 16'(pwm_ch.data.gesture));
                    check_field("servo_active", 16'(want_w.servo_active),
                                16'(pwm_ch.data.servo_active));
                    n_updates += want_w.pulse_update;
                    case (t_gesture'(want_w.gesture))
                        G_SINGLE: n_single++;
                        G_DOUBLE: n_double++;
                        G_LONG:   n_long++;
                        default: ;
                    endcase
                end
            end
        end
    end

    // result sink: random stall bursts, plus one long hold-off on request
    initial begin
        int held;
        pwm_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                pwm_ch.ready <= 1'b0;
                held = 0;
                while (held < LONG_STALL) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_output = 1'b0;
                pwm_ch.ready <= 1'b1;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                pwm_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            end else begin
                pwm_ch.ready <= 1'b1;
            end
        end
    end

    // Sends one tick word; called and returns at a falling edge.
    task automatic send_word(input logic edge_b, input logic lvl);
        if (!calm_tail && $urandom_range(0, 7) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t_in_word'{press_edge: edge_b, key_level: lvl};
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic press_for(input int n);
        int k;
        send_word(1'b1, 1'b0);
        for (k = 1; k < n; k++)
            send_word(1'b0, 1'b0);
    endtask

    task automatic release_for(input int n);
        repeat (n) send_word(1'b0, 1'b1);
    endtask

    task automatic chatter(input int n);
        repeat (n) send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic settle_block();
        tick_ch.valid <= 1'b0;
        while (pwm_expect_q.size() != 0) @(negedge i_clk);
    endtask

    // Writes all registers from cfg_plan; block must be idle.
    task automatic load_cfg();
        int r;
        for (r = 0; r < NUM_CFG; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_BITS'(r);
            i_cfg_data <= cfg_plan[r];
            @(posedge i_clk);
            cfg_regs[r] = cfg_plan[r];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_loads++;
    endtask

    task automatic plan_cfg(input logic [15:0] deb, input logic [15:0] lng,
                            input logic [15:0] gap, input logic [15:0] hold,
                            input logic [15:0] srv, input logic [15:0] p1,
                            input logic [15:0] p2, input logic [15:0] p3);
        cfg_plan[CFG_DEBOUNCE]     = deb;
        cfg_plan[CFG_LONG_PRESS]   = lng;
        cfg_plan[CFG_DOUBLE_GAP]   = gap;
        cfg_plan[CFG_HOLDOFF]      = hold;
        cfg_plan[CFG_SERVO_HOLD]   = srv;
        cfg_plan[CFG_PULSE_SINGLE] = p1;
        cfg_plan[CFG_PULSE_DOUBLE] = p2;
        cfg_plan[CFG_PULSE_LONG]   = p3;
        settle_block();
        load_cfg();
    endtask

    task automatic test_basic_gestures();
        plan_cfg(16'd2, 16'd40, 16'd40, 16'd5, 16'd8, 16'd1000, 16'd2000, 16'd3000);
        release_for(3);
        // single click
        press_for(12);
        release_for(60);
        // double click; the edge of the repeat press stays latched through the hold-off
        press_for(12);
        release_for(12);
        press_for(15);
        release_for(60);
        // long press
        press_for(60);
        release_for(60);
    endtask

    task automatic test_bounce_and_latch();
        // press too short to survive the debounce check
        press_for(2);
        release_for(20);
        // bounce on release goes back to held
        press_for(15);
        release_for(3);
        press_for(8);
        release_for(60);
        // edges with the key up while busy: picked up later, rejected at the check
        send_word(1'b1, 1'b1);
        release_for(30);
    endtask

    task automatic test_servo_busy_replace();
        plan_cfg(16'd1, 16'd40, 16'd10, 16'd0, 16'd220, 16'd111, 16'd222, 16'd333);
        press_for(60);
        release_for(20);
        press_for(10);
        release_for(30);
        press_for(60);
        release_for(30);
        release_for(150);
    endtask

    task automatic test_cfg_extremes();
        plan_cfg(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000, 16'h0000);
        press_for(12);
        release_for(25);
        chatter(10);
        plan_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF);
        press_for(15);
        release_for(15);
        chatter(10);
    endtask

    task automatic test_output_backpressure();
        plan_cfg(16'd0, 16'd20, 16'd10, 16'd0, 16'd3, 16'hA5A5, 16'h5A5A, 16'hFFFF);
        hold_output = 1'b1;
        press_for(30);
        release_for(40);
        press_for(6);
        release_for(40);
    endtask

    function automatic logic [15:0] pick_time(input int unsigned hi);
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, hi));
        endcase
    endfunction

    task automatic send_random_gesture();
        if ($urandom_range(0, 3) == 0)
            chatter($urandom_range(1, 4));
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                press_for($urandom_range(1, 25));
                release_for($urandom_range(1, 60));
            end
            3, 4, 5: begin
                press_for($urandom_range(1, 20));
                release_for($urandom_range(3, 25));
                press_for($urandom_range(1, 25));
                release_for($urandom_range(1, 60));
            end
            6, 7: begin
                press_for($urandom_range(25, 90));
                release_for($urandom_range(1, 60));
            end
            default: chatter($urandom_range(5, 25));
        endcase
    endtask

    task automatic test_random_gestures();
        int first_word;
        int reps;
        first_word = words_sent;
        while (words_sent - first_word < RANDOM_WORDS) begin
            plan_cfg(pick_time(12), pick_time(60), pick_time(40), pick_time(30),
                     pick_time(40), 16'($urandom), 16'($urandom), 16'($urandom));
            reps = $urandom_range(4, 10);
            while (reps > 0 && words_sent - first_word < RANDOM_WORDS) begin
                send_random_gesture();
                random_words = words_sent - first_word;
                if (random_words > CALM_AFTER)
                    calm_tail = 1'b1;
                reps--;
            end
        end
    endtask

    initial begin
        int r;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.data  <= '0;
        mismatches   = 0;
        words_sent   = 0;
        random_words = 0;
        cfg_loads    = 0;
        n_single     = 0;
        n_double     = 0;
        n_long       = 0;
        n_updates    = 0;
        calm_tail    = 1'b0;
        hold_output  = 1'b0;
        for (r = 0; r < NUM_CFG; r++)
            cfg_regs[r] = CFG_RESET[r];
        ms_now         = '0;
        last_scan      = '0;
        first_press_t  = '0;
        release_t      = '0;
        second_press_t = '0;
        gesture_end_t  = '0;
        servo_start_t  = '0;
        edge_latched   = 1'b0;
        rec_st         = R_IDLE;
        queued_gesture = G_NONE;
        servo_st       = S_FREE;
        cmp_val        = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // a few ticks at the reset settings first
        chatter(8);
        test_basic_gestures();
        test_bounce_and_latch();
        test_servo_busy_replace();
        test_cfg_extremes();
        test_output_backpressure();
        test_random_gestures();

        settle_block();
        repeat (4) @(negedge i_clk);

        $display("Ran %0d ticks over %0d register settings, incl. all-zero and all-ones.",
                 words_sent, cfg_loads);
        $display("Saw %0d single, %0d double, %0d long gestures; %0d servo updates.",
                 n_single, n_double, n_long, n_updates);
        if (mismatches == 0 && pwm_expect_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pwm_expect_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
